>>> rtl/spm_pkg.sv
// ---------------------------------------------------------------------------
// spm_pkg: shared constants and types for the stereo pan mixer
// Widths of samples, gains and sums, and the configuration register indexes.
// ---------------------------------------------------------------------------
package spm_pkg;

    localparam int NUM_SOURCES = 4;
    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_BITS   = 16;               // Q4.12 volume, master; Q1.15 pan
    localparam int OUT_BITS    = 24;
    localparam int GAIN_FRAC   = 12;
    localparam int PAN_FRAC    = 15;

    localparam logic [GAIN_BITS-1:0] PAN_ONE = GAIN_BITS'(32768);

    // gain after master scaling: (16 x 16) >> 12
    localparam int GM_BITS  = 2 * GAIN_BITS - GAIN_FRAC;
    // signed sample times zero-extended gain
    localparam int PROD_W   = SAMPLE_BITS + GM_BITS + 1;
    localparam int TERM_W   = PROD_W - GAIN_FRAC;
    localparam int SUM_W    = TERM_W + $clog2(NUM_SOURCES) + 1;
    localparam int ACC_W    = (SUM_W > OUT_BITS + 1) ? SUM_W : OUT_BITS + 1;

    // stages inside one lane before the merge stage
    localparam int LANE_STAGES = 3;

    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 5;

    typedef enum logic [1:0] {
        REG_VOLUME = 2'd0,
        REG_PAN    = 2'd1,
        REG_MASTER = 2'd2,
        REG_MODE   = 2'd3
    } t_reg_idx;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [TERM_W-1:0]      t_term;

endpackage

>>> rtl/stereo_pan_mixer.sv
// ---------------------------------------------------------------------------
// stereo_pan_mixer: four-source linear-pan stereo mixer
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   input    | i_in_valid / o_in_ready    | i_src{0..3}_left/right, i_block_end
//   output   | o_out_valid / i_out_ready  | o_mix_left, o_mix_right, o_frame_end
//   config   | psel, penable, pwrite      | paddr, pwdata, prdata (pready = 1)
//
// One frame per cycle while the output side takes mixes (three lane stages, one merge
// stage). The whole pipeline holds while the output register is full and not
// taken, so o_in_ready follows the output side. Reset clears the valid bits
// and loads the register reset values; no clearing pass is needed.
// ---------------------------------------------------------------------------
module stereo_pan_mixer (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    // frame input
    input  logic                                        i_in_valid,
    output logic                                        o_in_ready,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0]      i_src0_left,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0]      i_src0_right,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0]      i_src1_left,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0]      i_src1_right,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0]      i_src2_left,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0]      i_src2_right,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0]      i_src3_left,
    input  logic signed [spm_pkg::SAMPLE_BITS-1:0]      i_src3_right,
    input  logic                                        i_block_end,
    // mix output
    output logic                                        o_out_valid,
    input  logic                                        i_out_ready,
    output logic signed [spm_pkg::OUT_BITS-1:0]         o_mix_left,
    output logic signed [spm_pkg::OUT_BITS-1:0]         o_mix_right,
    output logic                                        o_frame_end,
    // configuration
    input  logic                                        psel,
    input  logic                                        penable,
    input  logic                                        pwrite,
    input  logic [spm_pkg::CFG_ADDR_W-1:0]              paddr,
    input  logic [spm_pkg::CFG_DATA_W-1:0]              pwdata,
    output logic [spm_pkg::CFG_DATA_W-1:0]              prdata,
    output logic                                        pready
);

    localparam int NS = spm_pkg::NUM_SOURCES;
    localparam int GB = spm_pkg::GAIN_BITS;
    localparam int LS = spm_pkg::LANE_STAGES;

    logic [4*GB-1:0]          r_volume_word;
    logic [4*GB-1:0]          r_pan_word;
    logic [GB-1:0]            r_master_gain;
    logic                     r_stereo_mode;

    logic                     cfg_wr;
    spm_pkg::t_reg_idx        cfg_idx;
    logic                     en;
    logic                     out_valid;

    logic [LS-1:0]            r_vld;
    logic [LS-1:0]            r_end;

    spm_pkg::t_sample [NS-1:0] src_left;
    spm_pkg::t_sample [NS-1:0] src_right;
    spm_pkg::t_term   [NS-1:0] term_l;
    spm_pkg::t_term   [NS-1:0] term_r;

    // register file
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = spm_pkg::t_reg_idx'(paddr[4:3]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume_word <= 64'h1000_1000_1000_1000;
            r_pan_word    <= 64'h4000_4000_4000_4000;
            r_master_gain <= GB'(4096);
            r_stereo_mode <= 1'b1;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                spm_pkg::REG_VOLUME: r_volume_word <= pwdata;
                spm_pkg::REG_PAN:    r_pan_word    <= pwdata;
                spm_pkg::REG_MASTER: r_master_gain <= pwdata[GB-1:0];
                spm_pkg::REG_MODE:   r_stereo_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            spm_pkg::REG_VOLUME: prdata = r_volume_word;
            spm_pkg::REG_PAN:    prdata = r_pan_word;
            spm_pkg::REG_MASTER: prdata = spm_pkg::CFG_DATA_W'(r_master_gain);
            spm_pkg::REG_MODE:   prdata = spm_pkg::CFG_DATA_W'(r_stereo_mode);
            default:             prdata = '0;
        endcase
    end

    // advance the pipeline unless a finished mix is waiting
    assign en         = !out_valid || i_out_ready;
    // refuse transfers while reset is held
    assign o_in_ready = en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LS-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_end <= {r_end[LS-2:0], i_block_end};
        end
    end

    assign src_left  = {i_src3_left,  i_src2_left,  i_src1_left,  i_src0_left};
    assign src_right = {i_src3_right, i_src2_right, i_src1_right, i_src0_right};

    for (genvar s = 0; s < NS; s++) begin : g_lane
        spm_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_vol    (r_volume_word[GB*s +: GB]),
            .i_pan    (r_pan_word[GB*s +: GB]),
            .i_master (r_master_gain),
            .i_left   (src_left[s]),
            .i_right  (src_right[s]),
            .o_term_l (term_l[s]),
            .o_term_r (term_r[s])
        );
    end

    spm_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (r_vld[LS-1]),
        .i_end       (r_end[LS-1]),
        .i_stereo    (r_stereo_mode),
        .i_term_l    (term_l),
        .i_term_r    (term_r),
        .o_valid     (out_valid),
        .o_end       (o_frame_end),
        .o_mix_left  (o_mix_left),
        .o_mix_right (o_mix_right)
    );

    assign o_out_valid = out_valid;

endmodule

>>> rtl/spm_lane.sv
// ---------------------------------------------------------------------------
// spm_lane: per-source gain and scaling lane
// Derives left and right gains from volume, pan and master, then scales the
// source's samples. Three register stages, all advanced by one enable.
// ---------------------------------------------------------------------------
module spm_lane (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [spm_pkg::GAIN_BITS-1:0]       i_vol,
    input  logic [spm_pkg::GAIN_BITS-1:0]       i_pan,
    input  logic [spm_pkg::GAIN_BITS-1:0]       i_master,
    input  spm_pkg::t_sample                    i_left,
    input  spm_pkg::t_sample                    i_right,
    output spm_pkg::t_term                      o_term_l,
    output spm_pkg::t_term                      o_term_r
);

    localparam int GB = spm_pkg::GAIN_BITS;
    localparam int GM = spm_pkg::GM_BITS;
    localparam int PW = spm_pkg::PROD_W;

    logic [GB-1:0]      pan_sat;
    logic [GB-1:0]      pan_inv;
    logic [2*GB-1:0]    prod_l1;
    logic [2*GB-1:0]    prod_r1;
    logic [2*GB-1:0]    prod_l2;
    logic [2*GB-1:0]    prod_r2;
    logic signed [PW-1:0] prod_l3;
    logic signed [PW-1:0] prod_r3;

    logic [GB-1:0]      r_gl;
    logic [GB-1:0]      r_gr;
    spm_pkg::t_sample   r_left1;
    spm_pkg::t_sample   r_right1;
    logic [GM-1:0]      r_glm;
    logic [GM-1:0]      r_grm;
    spm_pkg::t_sample   r_left2;
    spm_pkg::t_sample   r_right2;
    spm_pkg::t_term     r_term_l;
    spm_pkg::t_term     r_term_r;

    // stage 1: pan split
    always_comb begin
        pan_sat = (i_pan > spm_pkg::PAN_ONE) ? spm_pkg::PAN_ONE : i_pan;
        pan_inv = spm_pkg::PAN_ONE - pan_sat;
        prod_l1 = (2*GB)'(i_vol) * (2*GB)'(pan_inv);
        prod_r1 = (2*GB)'(i_vol) * (2*GB)'(pan_sat);
    end

    // stage 2: master gain
    always_comb begin
        prod_l2 = (2*GB)'(r_gl) * (2*GB)'(i_master);
        prod_r2 = (2*GB)'(r_gr) * (2*GB)'(i_master);
    end

    // stage 3: sample scaling, floor by arithmetic shift
    always_comb begin
        prod_l3 = PW'(r_left2)  * PW'($signed({1'b0, r_glm}));
        prod_r3 = PW'(r_right2) * PW'($signed({1'b0, r_grm}));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_gl     <= prod_l1[spm_pkg::PAN_FRAC +: GB];
            r_gr     <= prod_r1[spm_pkg::PAN_FRAC +: GB];
            r_left1  <= i_left;
            r_right1 <= i_right;
            r_glm    <= prod_l2[spm_pkg::GAIN_FRAC +: GM];
            r_grm    <= prod_r2[spm_pkg::GAIN_FRAC +: GM];
            r_left2  <= r_left1;
            r_right2 <= r_right1;
            r_term_l <= prod_l3[PW-1:spm_pkg::GAIN_FRAC];
            r_term_r <= prod_r3[PW-1:spm_pkg::GAIN_FRAC];
        end
    end

    assign o_term_l = r_term_l;
    assign o_term_r = r_term_r;

endmodule

>>> rtl/spm_merge.sv
// ---------------------------------------------------------------------------
// spm_merge: lane sum and saturation
// Adds the per-source terms, saturates to the output width and holds the
// result in the output register until the transfer completes.
// ---------------------------------------------------------------------------
module spm_merge (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  logic                                        i_end,
    input  logic                                        i_stereo,
    input  spm_pkg::t_term [spm_pkg::NUM_SOURCES-1:0]   i_term_l,
    input  spm_pkg::t_term [spm_pkg::NUM_SOURCES-1:0]   i_term_r,
    output logic                                        o_valid,
    output logic                                        o_end,
    output logic signed [spm_pkg::OUT_BITS-1:0]         o_mix_left,
    output logic signed [spm_pkg::OUT_BITS-1:0]         o_mix_right
);

    localparam int AW = spm_pkg::ACC_W;
    localparam int OB = spm_pkg::OUT_BITS;

    localparam logic signed [OB-1:0] OUT_MAX = {1'b0, {(OB-1){1'b1}}};
    localparam logic signed [OB-1:0] OUT_MIN = {1'b1, {(OB-1){1'b0}}};

    logic signed [AW-1:0] sum_l;
    logic signed [AW-1:0] sum_r;
    logic signed [OB-1:0] sat_l;
    logic signed [OB-1:0] sat_r;

    logic                 r_valid;
    logic                 r_end;
    logic signed [OB-1:0] r_mix_left;
    logic signed [OB-1:0] r_mix_right;

    function automatic logic signed [OB-1:0] sat_out(input logic signed [AW-1:0] v);
        logic fits;
        fits = (v[AW-1:OB-1] == {(AW-OB+1){1'b0}}) || (v[AW-1:OB-1] == {(AW-OB+1){1'b1}});
        if (fits) begin
            return v[OB-1:0];
        end else if (v[AW-1]) begin
            return OUT_MIN;
        end else begin
            return OUT_MAX;
        end
    endfunction

    always_comb begin
        sum_l = '0;
        sum_r = '0;
        for (int s = 0; s < spm_pkg::NUM_SOURCES; s++) begin
            sum_l = sum_l + AW'(i_term_l[s]);
            sum_r = sum_r + AW'(i_term_r[s]);
        end
        sat_l = sat_out(sum_l);
        // mono: right side drops out
        sat_r = i_stereo ? sat_out(sum_r) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_end       <= i_end;
            r_mix_left  <= sat_l;
            r_mix_right <= sat_r;
        end
    end

    assign o_valid     = r_valid;
    assign o_end       = r_end;
    assign o_mix_left  = r_mix_left;
    assign o_mix_right = r_mix_right;

endmodule

>>> tb/stereo_pan_mixer_tb.sv
// ---------------------------------------------------------------------------
// stereo_pan_mixer_tb: self-checking bench for the four-source pan mixer
// Drives frames through the valid/ready input, programs volume, pan, master
// gain and mode over the APB port, and checks every mix against a fixed-point
// model of the gain chain under changing idle and stall patterns.
// ---------------------------------------------------------------------------
module stereo_pan_mixer_tb;

    localparam int LATENCY     = 4;
    localparam int WDOG_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 62;
    localparam int DIR_FRAMES  = 6;

    typedef struct {
        spm_pkg::t_sample left  [spm_pkg::NUM_SOURCES];
        spm_pkg::t_sample right [spm_pkg::NUM_SOURCES];
        logic             block_end;
    } t_mix_frame;

    typedef struct {
        logic signed [spm_pkg::OUT_BITS-1:0] mix_left;
        logic signed [spm_pkg::OUT_BITS-1:0] mix_right;
        logic                                frame_end;
    } t_mix_out;

    class mix_scoreboard;
        logic [63:0]                   volume_word = 64'h1000_1000_1000_1000;
        logic [63:0]                   pan_word    = 64'h4000_4000_4000_4000;
        logic [spm_pkg::GAIN_BITS-1:0] master_gain = 16'd4096;
        logic                          stereo_mode = 1'b1;
        t_mix_out                      pending[$];
        int                            errors      = 0;
        int                            frames_in   = 0;
        int                            mixes_out   = 0;
        int                            mono_frames = 0;
        int                            clipped     = 0;

        function void set_reg(spm_pkg::t_reg_idx idx, logic [63:0] value);
            case (idx)
                spm_pkg::REG_VOLUME: volume_word = value;
                spm_pkg::REG_PAN:    pan_word    = value;
                spm_pkg::REG_MASTER: master_gain = value[spm_pkg::GAIN_BITS-1:0];
                spm_pkg::REG_MODE:   stereo_mode = value[0];
                default: ;
            endcase
        endfunction

        function logic [63:0] reg_value(spm_pkg::t_reg_idx idx);
            case (idx)
                spm_pkg::REG_VOLUME: return volume_word;
                spm_pkg::REG_PAN:    return pan_word;
                spm_pkg::REG_MASTER: return {48'd0, master_gain};
                default:             return {63'd0, stereo_mode};
            endcase
        endfunction

        function longint clamp24(longint v);
            if (v > 64'sd8388607 || v < -64'sd8388608)
                clipped++;
            if (v > 64'sd8388607)
                return 64'sd8388607;
            if (v < -64'sd8388608)
                return -64'sd8388608;
            return v;
        endfunction

        // left gain = vol*(1-pan)*master, right gain = vol*pan*master, all truncating
        function t_mix_out predict_mix(t_mix_frame f);
            longint   acc_l, acc_r, vol, pan, gl, gr, mst;
            t_mix_out res;
            acc_l = 0;
            acc_r = 0;
            mst   = longint'({48'd0, master_gain});
            for (int s = 0; s < spm_pkg::NUM_SOURCES; s++) begin
                vol = longint'({48'd0, volume_word[16*s +: 16]});
                pan = longint'({48'd0, pan_word[16*s +: 16]});
                if (pan > 32768)
                    pan = 32768;
                gl = (vol * (32768 - pan)) >>> spm_pkg::PAN_FRAC;
                gr = (vol * pan) >>> spm_pkg::PAN_FRAC;
                gl = (gl * mst) >>> spm_pkg::GAIN_FRAC;
                gr = (gr * mst) >>> spm_pkg::GAIN_FRAC;
                acc_l += (longint'(f.left[s]) * gl) >>> spm_pkg::GAIN_FRAC;
                if (stereo_mode)
                    acc_r += (longint'(f.right[s]) * gr) >>> spm_pkg::GAIN_FRAC;
            end
            res.mix_left  = spm_pkg::OUT_BITS'(clamp24(acc_l));
            res.mix_right = stereo_mode ? spm_pkg::OUT_BITS'(clamp24(acc_r)) : '0;
            res.frame_end = f.block_end;
            return res;
        endfunction

        function void note_frame(t_mix_frame f);
            frames_in++;
            if (!stereo_mode)
                mono_frames++;
            pending.insert(pending.size(), predict_mix(f));
        endfunction

        function void check_mix(logic signed [spm_pkg::OUT_BITS-1:0] l,
                                logic signed [spm_pkg::OUT_BITS-1:0] r, logic fe);
            t_mix_out want;
            mixes_out++;
            if (pending.size() == 0) begin
                $error("mix output with no frame outstanding: left %0d right %0d", l, r);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (l !== want.mix_left) begin
                $error("mix_left: expected %0d, got %0d", want.mix_left, l);
                errors++;
            end
            if (r !== want.mix_right) begin
                $error("mix_right: expected %0d, got %0d", want.mix_right, r);
                errors++;
            end
            if (fe !== want.frame_end) begin
                $error("frame_end: expected %0b, got %0b", want.frame_end, fe);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] i_src0_left = '0, i_src0_right = '0;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] i_src1_left = '0, i_src1_right = '0;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] i_src2_left = '0, i_src2_right = '0;
    logic signed [spm_pkg::SAMPLE_BITS-1:0] i_src3_left = '0, i_src3_right = '0;
    logic                    i_block_end = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [spm_pkg::OUT_BITS-1:0] o_mix_left, o_mix_right;
    logic                    o_frame_end;
    logic                    psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [spm_pkg::CFG_ADDR_W-1:0] paddr = '0;
    logic [spm_pkg::CFG_DATA_W-1:0] pwdata = '0;
    logic [spm_pkg::CFG_DATA_W-1:0] prdata;
    logic                    pready;

    mix_scoreboard sb;
    int            sender_idle_pct = 0;
    int            stall_pct = 0;
    int            hold_requests = 0;
    int            settings_used = 1;

    stereo_pan_mixer i_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // output side: check transfers, stall at random, serve hold-off requests
    initial begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_ready)
                sb.check_mix(o_mix_left, o_mix_right, o_frame_end);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        int quiet;
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)
                || psel || !i_rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet >= WDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic cfg_write(spm_pkg::t_reg_idx idx, logic [63:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= spm_pkg::CFG_ADDR_W'(int'(idx) * 8);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic check_regs();
        logic [63:0]       got;
        spm_pkg::t_reg_idx idx;
        for (int i = 0; i < 4; i++) begin
            idx = spm_pkg::t_reg_idx'(i);
            @(posedge i_clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= spm_pkg::CFG_ADDR_W'(i * 8);
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            got = prdata;
            psel    <= 1'b0;
            penable <= 1'b0;
            if (got !== sb.reg_value(idx)) begin
                $error("%s readback: expected %h, got %h", idx.name(), sb.reg_value(idx), got);
                sb.errors++;
            end
        end
    endtask

    // idle per cycle at the sender's rate, then hold the frame until taken
    task automatic send_frame(t_mix_frame f);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_src0_left  <= f.left[0];
        i_src0_right <= f.right[0];
        i_src1_left  <= f.left[1];
        i_src1_right <= f.right[1];
        i_src2_left  <= f.left[2];
        i_src2_right <= f.right[2];
        i_src3_left  <= f.left[3];
        i_src3_right <= f.right[3];
        i_block_end  <= f.block_end;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_frame(f);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    function automatic t_mix_frame directed_frame(int k);
        t_mix_frame f;
        for (int s = 0; s < spm_pkg::NUM_SOURCES; s++) begin
            case (k)
                0: begin f.left[s] = -16'sd1;       f.right[s] = 16'sd1;        end
                1: begin f.left[s] = 16'sh7FFF;     f.right[s] = 16'sh7FFF;     end
                2: begin f.left[s] = -16'sh8000;    f.right[s] = -16'sh8000;    end
                3: begin f.left[s] = 16'sh7FFF;     f.right[s] = -16'sh8000;    end
                4: begin
                    f.left[s]  = s[0] ? -16'sh8000 : 16'sh7FFF;
                    f.right[s] = s[0] ? 16'sh7FFF : -16'sh8000;
                end
                default: begin f.left[s] = 16'sh5555; f.right[s] = 16'shAAAA; end
            endcase
        end
        f.block_end = k[0];
        return f;
    endfunction

    function automatic spm_pkg::t_sample rand_sample();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return -16'sh8000;
            2:       return '0;
            default: return spm_pkg::t_sample'($urandom);
        endcase
    endfunction

    function automatic t_mix_frame rand_frame();
        t_mix_frame f;
        for (int s = 0; s < spm_pkg::NUM_SOURCES; s++) begin
            f.left[s]  = rand_sample();
            f.right[s] = rand_sample();
        end
        f.block_end = ($urandom_range(3) == 0);
        return f;
    endfunction

    function automatic logic [15:0] rand_gain();
        case ($urandom_range(5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h1000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_pan();
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    // reset values, then full gain with pan at and beyond the right end,
    // mono with mixed gains, and everything muted
    task automatic apply_directed(int k);
        case (k)
            1: begin
                cfg_write(spm_pkg::REG_VOLUME, 64'hFFFF_FFFF_FFFF_FFFF);
                cfg_write(spm_pkg::REG_PAN,    64'h0000_8000_8001_FFFF);
                cfg_write(spm_pkg::REG_MASTER, 64'hDEAD_BEEF_CAFE_FFFF);
                cfg_write(spm_pkg::REG_MODE,   64'h0000_0000_0000_0001);
            end
            2: begin
                cfg_write(spm_pkg::REG_VOLUME, 64'h7FFF_1000_0001_FFFF);
                cfg_write(spm_pkg::REG_PAN,    64'h2000_6000_0000_8000);
                cfg_write(spm_pkg::REG_MASTER, 64'h0000_0000_0000_1000);
                cfg_write(spm_pkg::REG_MODE,   64'hFFFF_FFFF_FFFF_FFFE);
            end
            3: begin
                cfg_write(spm_pkg::REG_VOLUME, 64'h0000_0000_0000_0000);
                cfg_write(spm_pkg::REG_PAN,    64'hFFFF_FFFF_FFFF_FFFF);
                cfg_write(spm_pkg::REG_MASTER, 64'hFFFF_FFFF_FFFF_0000);
                cfg_write(spm_pkg::REG_MODE,   64'hFFFF_FFFF_FFFF_FFFF);
            end
            default: ;
        endcase
    endtask

    initial begin
        logic [63:0] word;
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        check_regs();
        for (int k = 0; k < 4; k++) begin
            if (k > 0) begin
                apply_directed(k);
                check_regs();
                settings_used++;
            end
            for (int j = 0; j < DIR_FRAMES; j++)
                send_frame(directed_frame(j));
            i_in_valid <= 1'b0;
            drain();
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            for (int s = 0; s < spm_pkg::NUM_SOURCES; s++)
                word[16*s +: 16] = rand_gain();
            cfg_write(spm_pkg::REG_VOLUME, word);
            for (int s = 0; s < spm_pkg::NUM_SOURCES; s++)
                word[16*s +: 16] = rand_pan();
            cfg_write(spm_pkg::REG_PAN, word);
            word = {$urandom, $urandom};
            word[15:0] = rand_gain();
            cfg_write(spm_pkg::REG_MASTER, word);
            word = {$urandom, $urandom};
            word[0] = ($urandom_range(2) != 0);
            cfg_write(spm_pkg::REG_MODE, word);
            check_regs();
            settings_used++;

            case (p % 4)
                0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
                1:       begin sender_idle_pct = 45; stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  stall_pct = 45; end
                default: begin sender_idle_pct = 9;  stall_pct = 9;  end
            endcase
            // long output hold while frames keep coming, to back up the input
            if (p == 4)
                hold_requests++;

            for (int n = 0; n < PHASE_ITEMS; n++)
                send_frame(rand_frame());
            i_in_valid <= 1'b0;
            drain();
        end

        $display("Mixed %0d frames (%0d outputs) over %0d register settings, %0d in mono.",
                 sb.frames_in, sb.mixes_out, settings_used, sb.mono_frames);
        $display("Clipped sums: %0d; pan past full right, zero and full-scale gains, idle and",
                 sb.clipped);
        $display("stall patterns and an output hold-off with input backpressure were covered.");
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
